FILE: hw/rtl/pobw_pkg.sv
// Package for the priority override weighted blend unit.
// Holds shared constants, blend mode codes, the per-query snapshot type and the divider types.
// No dependencies.
`timescale 1ns / 1ps

package pobw_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int TEMP_W = 23;
	localparam int TOT_W = 23;
	localparam int SUM_W = 46;
	localparam int INFL_W = 17;
	localparam int DVD_W = 47;
	localparam logic [INFL_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [TEMP_W-1:0] TEMP_MAX = 23'h7FFFFF;

	typedef enum logic {
		MODE_WEIGHTED = 1'b0,
		MODE_OVERRIDE = 1'b1
	} blend_mode_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] wsum;
		logic [TOT_W-1:0] wtot;
		logic signed [SUM_W-1:0] osum;
		logic [TOT_W-1:0] otot;
		logic [INFL_W-1:0] alpha;
		logic ovr;
		logic [TEMP_W-1:0] fb_base;
	} pobw_snap_t;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [TOT_W-1:0] divisor;
	} pobw_div_req_t;

	typedef struct packed {
		logic done;
		logic [TEMP_W-1:0] quotient;
	} pobw_div_rsp_t;

endpackage

FILE: hw/rtl/pobw_if.sv
// Channel interfaces for source contributions and blended results.
// Depends on nothing; payload widths follow the item formats.
`timescale 1ns / 1ps

interface pobw_in_if;
	logic valid;
	logic ready;
	logic has_field;
	logic signed [17:0] field_influence;
	logic signed [23:0] field_temperature;
	logic blend_mode;
	logic signed [15:0] priority_req;
	logic signed [23:0] fallback_temperature;
	logic last;

	modport source (
		output valid, has_field, field_influence, field_temperature, blend_mode,
		output priority_req, fallback_temperature, last,
		input ready
	);
	modport sink (
		input valid, has_field, field_influence, field_temperature, blend_mode,
		input priority_req, fallback_temperature, last,
		output ready
	);
endinterface

interface pobw_out_if;
	logic valid;
	logic ready;
	logic [22:0] temperature;
	logic used_fallback;
	logic override_applied;

	modport source (output valid, temperature, used_fallback, override_applied, input ready);
	modport sink (input valid, temperature, used_fallback, override_applied, output ready);
endinterface

FILE: hw/rtl/pobw_front.sv
// Front end: accepts contributions, clamps influence and accumulates the sums.
// Depends on pobw_pkg and pobw_in_if; pushes one snapshot per query.
`timescale 1ns / 1ps

module pobw_front (
	input  logic clk,
	input  logic arst_n,
	pobw_in_if.sink items,
	output logic push,
	output pobw_pkg::pobw_snap_t push_data,
	input  logic full
);
	import pobw_pkg::*;

	logic signed [SUM_W-1:0] wsum_q, osum_q, wsum_n, osum_n;
	logic [TOT_W-1:0] wtot_q, otot_q, wtot_n, otot_n;
	logic seen_q, seen_n;
	logic signed [15:0] best_q, best_n;
	logic [INFL_W-1:0] alpha_q, alpha_n;
	logic [INFL_W-1:0] infl_c;
	logic contrib, accept;
	logic signed [41:0] prod;
	logic signed [SUM_W:0] wsum_add, osum_add;
	logic [TOT_W:0] wtot_add, otot_add;

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] s);
		logic signed [SUM_W-1:0] r;
		if (s[SUM_W] != s[SUM_W-1]) begin
			r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			r = s[SUM_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W:0] s);
		return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
	endfunction

	assign items.ready = !full;
	assign accept = items.valid && items.ready;

	always_comb begin
		if (items.field_influence[17]) begin
			infl_c = '0;
		end else if (items.field_influence > $signed({1'b0, ONE_Q16})) begin
			infl_c = ONE_Q16;
		end else begin
			infl_c = items.field_influence[INFL_W-1:0];
		end
	end

	assign contrib = items.has_field && (infl_c != '0);
	assign prod = 42'(items.field_temperature) * 42'($signed({1'b0, infl_c}));
	assign wsum_add = {wsum_q[SUM_W-1], wsum_q} + {{(SUM_W-41){prod[41]}}, prod};
	assign osum_add = {osum_q[SUM_W-1], osum_q} + {{(SUM_W-41){prod[41]}}, prod};
	assign wtot_add = {1'b0, wtot_q} + {{(TOT_W-INFL_W+1){1'b0}}, infl_c};
	assign otot_add = {1'b0, otot_q} + {{(TOT_W-INFL_W+1){1'b0}}, infl_c};

	always_comb begin
		wsum_n = wsum_q;
		wtot_n = wtot_q;
		seen_n = seen_q;
		best_n = best_q;
		osum_n = osum_q;
		otot_n = otot_q;
		alpha_n = alpha_q;
		if (contrib && (items.blend_mode == MODE_WEIGHTED)) begin
			wsum_n = sat_sum(wsum_add);
			wtot_n = sat_tot(wtot_add);
		end else if (contrib) begin
			if (!seen_q || items.priority_req > best_q) begin
				seen_n = 1'b1;
				best_n = items.priority_req;
				osum_n = SUM_W'(prod);
				otot_n = TOT_W'(infl_c);
				alpha_n = infl_c;
			end else if (items.priority_req == best_q) begin
				osum_n = sat_sum(osum_add);
				otot_n = sat_tot(otot_add);
				if (infl_c > alpha_q) begin
					alpha_n = infl_c;
				end
			end
		end
	end

	assign push = accept && items.last;

	always_comb begin
		push_data.wsum = wsum_n;
		push_data.wtot = wtot_n;
		push_data.osum = osum_n;
		push_data.otot = otot_n;
		push_data.alpha = alpha_n;
		push_data.ovr = seen_n && (otot_n != '0);
		push_data.fb_base = items.fallback_temperature[23] ? '0
			: items.fallback_temperature[TEMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			wtot_q <= '0;
			seen_q <= 1'b0;
			best_q <= '0;
			osum_q <= '0;
			otot_q <= '0;
			alpha_q <= '0;
		end else if (accept && items.last) begin
			wsum_q <= '0;
			wtot_q <= '0;
			seen_q <= 1'b0;
			best_q <= '0;
			osum_q <= '0;
			otot_q <= '0;
			alpha_q <= '0;
		end else if (accept) begin
			wsum_q <= wsum_n;
			wtot_q <= wtot_n;
			seen_q <= seen_n;
			best_q <= best_n;
			osum_q <= osum_n;
			otot_q <= otot_n;
			alpha_q <= alpha_n;
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && items.last |=> (wtot_q == '0) && !seen_q && (otot_q == '0))
		else $error("Accumulators not cleared after the closing transaction.");
	a_alpha_bound: assert property (@(posedge clk) disable iff (!arst_n)
		alpha_q <= ONE_Q16 && (seen_q || alpha_q == '0))
		else $error("Override alpha out of range or set without an override group.");
`endif

endmodule

FILE: hw/rtl/pobw_queue.sv
// Short snapshot queue between the accumulating front end and the divide back end.
// Depends on pobw_pkg for the snapshot type.
`timescale 1ns / 1ps

module pobw_queue #(
	parameter int DEPTH = pobw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pobw_pkg::pobw_snap_t push_data,
	output logic full,
	input  logic pop,
	output pobw_pkg::pobw_snap_t pop_data,
	output logic empty
);
	import pobw_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pobw_snap_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("Snapshot pushed into a full queue.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("Snapshot popped from an empty queue.");
`endif

endmodule

FILE: hw/rtl/pobw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, result saturated to 23 bits.
// Depends on pobw_pkg for the request and response types.
`timescale 1ns / 1ps

module pobw_div (
	input  logic clk,
	input  logic arst_n,
	input  pobw_pkg::pobw_div_req_t req,
	output pobw_pkg::pobw_div_rsp_t rsp
);
	import pobw_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [TOT_W-1:0] rem_q, dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [TOT_W:0] trial;
	logic fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? TOT_W'(trial - {1'b0, dsr_q}) : trial[TOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = (|dvd_q[DVD_W-1:TEMP_W]) ? TEMP_MAX : dvd_q[TEMP_W-1:0];

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && !done_q)
		else $error("Divide started while the divider was still working.");
`endif

endmodule

FILE: hw/rtl/pobw_back.sv
// Back end: takes query snapshots, forms both means with the shared divider and blends.
// Depends on pobw_pkg and pobw_out_if; drives the result output register.
`timescale 1ns / 1ps

module pobw_back (
	input  logic clk,
	input  logic arst_n,
	input  pobw_pkg::pobw_snap_t pop_data,
	input  logic empty,
	output logic pop,
	output pobw_pkg::pobw_div_req_t div_req,
	input  pobw_pkg::pobw_div_rsp_t div_rsp,
	pobw_out_if.source results
);
	import pobw_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP_W = 3'd1;
	localparam logic [2:0] ST_WDIV = 3'd2;
	localparam logic [2:0] ST_PREP_O = 3'd3;
	localparam logic [2:0] ST_ODIV = 3'd4;
	localparam logic [2:0] ST_MUL = 3'd5;
	localparam logic [2:0] ST_ADD = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;

	logic [2:0] state_q;
	pobw_snap_t snap_q;
	logic [TEMP_W-1:0] base_q, ovr_q, res_q;
	logic [39:0] prod_q;
	logic [40:0] blend;
	logic [INFL_W-1:0] inv_alpha;
	logic out_valid_q, used_fb_q, ovr_applied_q;
	logic [TEMP_W-1:0] out_temp_q;
	logic out_free;

	assign out_free = !out_valid_q || results.ready;
	assign pop = (state_q == ST_IDLE) && !empty;
	assign inv_alpha = ONE_Q16 - snap_q.alpha;
	assign blend = {1'b0, prod_q} + 41'(ovr_q) * 41'(snap_q.alpha) + 41'd32768;

	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = {2'b00, snap_q.wsum[SUM_W-2:0]}
			+ {{(DVD_W-TOT_W+1){1'b0}}, snap_q.wtot[TOT_W-1:1]};
		div_req.divisor = snap_q.wtot;
		if (state_q == ST_PREP_W) begin
			div_req.start = (snap_q.wtot != '0) && !snap_q.wsum[SUM_W-1]
				&& (snap_q.wsum != '0);
		end else if (state_q == ST_PREP_O) begin
			div_req.start = snap_q.ovr && !snap_q.osum[SUM_W-1] && (snap_q.osum != '0);
			div_req.dividend = {2'b00, snap_q.osum[SUM_W-2:0]}
				+ {{(DVD_W-TOT_W+1){1'b0}}, snap_q.otot[TOT_W-1:1]};
			div_req.divisor = snap_q.otot;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					snap_q <= pop_data;
				end
			end
			ST_PREP_W: begin
				base_q <= (snap_q.wtot == '0) ? snap_q.fb_base : '0;
			end
			ST_WDIV: begin
				if (div_rsp.done) begin
					base_q <= div_rsp.quotient;
				end
			end
			ST_PREP_O: begin
				ovr_q <= '0;
				res_q <= base_q;
			end
			ST_ODIV: begin
				if (div_rsp.done) begin
					ovr_q <= div_rsp.quotient;
				end
			end
			ST_MUL: begin
				prod_q <= 40'(base_q) * 40'(inv_alpha);
			end
			ST_ADD: begin
				res_q <= (|blend[40:39]) ? TEMP_MAX : blend[38:16];
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (!empty) state_q <= ST_PREP_W;
				ST_PREP_W: state_q <= div_req.start ? ST_WDIV : ST_PREP_O;
				ST_WDIV: if (div_rsp.done) state_q <= ST_PREP_O;
				ST_PREP_O: begin
					if (!snap_q.ovr) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= div_req.start ? ST_ODIV : ST_MUL;
					end
				end
				ST_ODIV: if (div_rsp.done) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_OUT;
				ST_OUT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_temp_q <= res_q;
			used_fb_q <= (snap_q.wtot == '0);
			ovr_applied_q <= snap_q.ovr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid = out_valid_q;
	assign results.temperature = out_temp_q;
	assign results.used_fallback = used_fb_q;
	assign results.override_applied = ovr_applied_q;

`ifndef SYNTHESIS
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_WDIV) || (state_q == ST_ODIV))
		else $error("Divider finished while no division was pending.");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |=> out_valid_q && $stable(out_temp_q))
		else $error("Stalled result changed before its transaction.");
`endif

endmodule

FILE: hw/rtl/priority_override_weighted_blend_unit.sv
// Priority override weighted blend unit: one contribution transaction per cycle while the
// snapshot queue has room; the closing transaction is accumulated in the cycle it is taken.
// Each mean that needs a division goes through the shared one-bit-per-cycle divider in the
// back end, and an override group adds a multiply step and an add step before the result.
// Asynchronous active-low reset clears the accumulators, the queue and the result valid.
`timescale 1ns / 1ps

module priority_override_weighted_blend_unit #(
	parameter int QUEUE_DEPTH = pobw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pobw_in_if.sink items,
	pobw_out_if.source results
);
	import pobw_pkg::*;

	pobw_snap_t push_data, pop_data;
	logic push, pop, full, empty;
	pobw_div_req_t div_req;
	pobw_div_rsp_t div_rsp;

	pobw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	pobw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	pobw_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	pobw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_data(pop_data),
		.empty(empty),
		.pop(pop),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.results(results)
	);

endmodule

FILE: verif/priority_override_weighted_blend_unit_tb.sv
// Testbench for the priority override weighted blend unit: directed rows from a stimulus table,
// then random queries, each result checked against the row's expected value or a cycle-free blend predictor.
// Depends on pobw_pkg, the pobw_in_if and pobw_out_if channel interfaces and the unit itself.
`timescale 1ns / 1ps

module priority_override_weighted_blend_unit_tb;
	import pobw_pkg::*;

	localparam int RANDOM_ITEMS = 550;
	localparam int CALM_ITEMS = 60;
	localparam int DRAIN_CYCLES = 120;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_HOLD_AT = 20;
	localparam int PAUSE_QUERY = 30;
	localparam int SAT_QUERY = 45;
	localparam int SAT_LEN = 130;
	localparam longint SUM_LIM = (longint'(1) << (SUM_W - 1)) - 1;
	localparam longint TOT_LIM = (longint'(1) << TOT_W) - 1;
	localparam longint UNITY = longint'(ONE_Q16);

	typedef struct packed {
		bit has;
		logic signed [17:0] infl;
		logic signed [23:0] temp;
		blend_mode_t mode;
		logic signed [15:0] prio;
		logic signed [23:0] fb;
		bit last;
	} contrib_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature;
		logic used_fb;
		logic ovr_applied;
	} blend_t;

	typedef struct {
		contrib_t item;
		bit typed;
		blend_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pobw_in_if contrib_ch();
	pobw_out_if blend_ch();

	priority_override_weighted_blend_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(contrib_ch),
		.results(blend_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic signed [SUM_W-1:0] w_sum = '0;
	logic [TOT_W-1:0] w_tot = '0;
	logic o_seen = 1'b0;
	logic signed [15:0] o_prio = '0;
	logic signed [SUM_W-1:0] o_sum = '0;
	logic [TOT_W-1:0] o_tot = '0;
	logic [INFL_W-1:0] o_alpha = '0;

	blend_t pending[$];
	stim_row_t stim_table[$];
	int fault_count = 0;
	int results_seen = 0;
	int items_sent = 0;
	bit calm = 1'b0;
	bit sender_gaps = 1'b0;

	function automatic logic signed [SUM_W-1:0] sum_sat(logic signed [SUM_W-1:0] a, longint b);
		longint s;
		s = longint'(a) + b;
		if (s > SUM_LIM) s = SUM_LIM;
		else if (s < -SUM_LIM - 1) s = -SUM_LIM - 1;
		return s[SUM_W-1:0];
	endfunction

	function automatic logic [TOT_W-1:0] tot_sat(logic [TOT_W-1:0] a, longint b);
		longint s;
		s = longint'(a) + b;
		if (s > TOT_LIM) s = TOT_LIM;
		return s[TOT_W-1:0];
	endfunction

	function automatic longint mean_q8(longint sum, longint tot);
		longint q;
		if (sum <= 0 || tot == 0) return 0;
		q = (sum + tot / 2) / tot;
		return (q > longint'(TEMP_MAX)) ? longint'(TEMP_MAX) : q;
	endfunction

	function automatic bit blend_step(input contrib_t c, output blend_t r);
		longint infl, prod, base, ovr, mix;
		bit no_weight, grp_live;
		infl = longint'(c.infl);
		if (infl < 0) infl = 0;
		if (infl > UNITY) infl = UNITY;
		r = '0;
		if (c.has && infl > 0) begin
			prod = longint'(c.temp) * infl;
			if (c.mode == MODE_WEIGHTED) begin
				w_sum = sum_sat(w_sum, prod);
				w_tot = tot_sat(w_tot, infl);
			end else if (!o_seen || c.prio >= o_prio) begin
				if (!o_seen || c.prio > o_prio) begin
					o_seen = 1'b1;
					o_prio = c.prio;
					o_sum = '0;
					o_tot = '0;
					o_alpha = '0;
				end
				o_sum = sum_sat(o_sum, prod);
				o_tot = tot_sat(o_tot, infl);
				if (infl > longint'(o_alpha)) o_alpha = infl[INFL_W-1:0];
			end
		end
		if (!c.last) return 1'b0;
		no_weight = (w_tot == 0);
		if (no_weight) base = (c.fb > 0) ? longint'(c.fb) : 0;
		else base = mean_q8(longint'(w_sum), longint'(w_tot));
		mix = base;
		grp_live = o_seen && (o_tot != 0);
		if (grp_live) begin
			ovr = mean_q8(longint'(o_sum), longint'(o_tot));
			mix = (base * (UNITY - longint'(o_alpha)) + ovr * longint'(o_alpha) + 32768) >>> 16;
			if (mix > longint'(TEMP_MAX)) mix = longint'(TEMP_MAX);
		end
		r.temperature = mix[TEMP_W-1:0];
		r.used_fb = no_weight;
		r.ovr_applied = grp_live;
		w_sum = '0;
		w_tot = '0;
		o_seen = 1'b0;
		o_prio = '0;
		o_sum = '0;
		o_tot = '0;
		o_alpha = '0;
		return 1'b1;
	endfunction

	function automatic void add_row(bit has, int infl, int temp, blend_mode_t mode, int prio,
			int fb, bit last, bit typed = 1'b0, int t = 0, bit uf = 1'b0, bit oa = 1'b0);
		stim_row_t row;
		row.item.has = has;
		row.item.infl = 18'(infl);
		row.item.temp = 24'(temp);
		row.item.mode = mode;
		row.item.prio = 16'(prio);
		row.item.fb = 24'(fb);
		row.item.last = last;
		row.typed = typed;
		row.want.temperature = t[TEMP_W-1:0];
		row.want.used_fb = uf;
		row.want.ovr_applied = oa;
		stim_table.insert(stim_table.size(), row);
	endfunction

	function automatic contrib_t random_contrib(bit closing);
		contrib_t c;
		c.has = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: c.infl = 18'($urandom_range(1, 65536));
			5: c.infl = 18'(65536);
			6: c.infl = 18'(-int'($urandom_range(0, 131072)));
			7: c.infl = 18'($urandom_range(65537, 131071));
			default: c.infl = 18'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0, 1, 2, 3: c.temp = 24'($urandom_range(0, 1000 * 256));
			4: c.temp = 24'(-int'($urandom_range(1, 100 * 256)));
			5: c.temp = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			default: c.temp = 24'($urandom);
		endcase
		c.mode = blend_mode_t'($urandom_range(0, 1));
		if ($urandom_range(0, 3) != 0) c.prio = 16'(int'($urandom_range(0, 3)) - 1);
		else c.prio = 16'($urandom);
		case ($urandom_range(0, 3))
			0, 1: c.fb = 24'($urandom_range(0, 400 * 256));
			2: c.fb = 24'(-int'($urandom_range(1, 8388608)));
			default: c.fb = 24'($urandom);
		endcase
		c.last = closing;
		return c;
	endfunction

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10) $display("%0t ns: %s", $time, msg);
	endfunction

	function automatic void take_result();
		blend_t got, want;
		got.temperature = blend_ch.temperature;
		got.used_fb = blend_ch.used_fallback;
		got.ovr_applied = blend_ch.override_applied;
		results_seen++;
		if (pending.size() == 0) begin
			note_fault($sformatf(
				"result with none pending: temperature %0d, used_fallback %0b, override_applied %0b",
				got.temperature, got.used_fb, got.ovr_applied));
			return;
		end
		want = pending.pop_front();
		if (got.temperature !== want.temperature)
			note_fault($sformatf("temperature: expected %0d, got %0d",
				want.temperature, got.temperature));
		if (got.used_fb !== want.used_fb)
			note_fault($sformatf("used_fallback: expected %0b, got %0b", want.used_fb, got.used_fb));
		if (got.ovr_applied !== want.ovr_applied)
			note_fault($sformatf("override_applied: expected %0b, got %0b",
				want.ovr_applied, got.ovr_applied));
	endfunction

	task automatic idle_items(input int n);
		contrib_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic push_item(input contrib_t c, input bit typed, input blend_t want);
		blend_t predicted;
		contrib_ch.valid <= 1'b1;
		contrib_ch.has_field <= c.has;
		contrib_ch.field_influence <= c.infl;
		contrib_ch.field_temperature <= c.temp;
		contrib_ch.blend_mode <= c.mode;
		contrib_ch.priority_req <= c.prio;
		contrib_ch.fallback_temperature <= c.fb;
		contrib_ch.last <= c.last;
		do @(posedge clk); while (!contrib_ch.ready);
		if (blend_step(c, predicted)) pending.insert(pending.size(), typed ? want : predicted);
		items_sent++;
	endtask

	task automatic offer(input contrib_t c);
		if (sender_gaps && !calm && $urandom_range(0, 3) == 0) idle_items($urandom_range(1, 6));
		push_item(c, 1'b0, '0);
	endtask

	initial begin : stimulus
		contrib_t c;
		int qn, len, kind, target;
		contrib_ch.valid <= 1'b0;
		contrib_ch.has_field <= 1'b0;
		contrib_ch.field_influence <= '0;
		contrib_ch.field_temperature <= '0;
		contrib_ch.blend_mode <= 1'b0;
		contrib_ch.priority_req <= '0;
		contrib_ch.fallback_temperature <= '0;
		contrib_ch.last <= 1'b0;

		add_row(0, 0, 0, MODE_WEIGHTED, 0, 0, 1, 1, 0, 1, 0);
		add_row(0, 131071, 8388607, MODE_OVERRIDE, 32767, -8388608, 1, 1, 0, 1, 0);
		add_row(0, 0, 0, MODE_WEIGHTED, 0, 8388607, 1, 1, 8388607, 1, 0);
		add_row(1, 65536, 8388607, MODE_WEIGHTED, 0, 0, 1, 1, 8388607, 0, 0);
		add_row(1, 131071, -8388608, MODE_WEIGHTED, 0, 0, 1, 1, 0, 0, 0);
		add_row(1, -131072, 5000, MODE_WEIGHTED, 0, 300, 1, 1, 300, 1, 0);
		add_row(1, 0, 5000, MODE_OVERRIDE, 0, 300, 1, 1, 300, 1, 0);
		add_row(1, 1, 256, MODE_WEIGHTED, 0, 0, 1, 1, 256, 0, 0);
		add_row(1, 65536, 2560, MODE_OVERRIDE, 0, 0, 1, 1, 2560, 1, 1);
		add_row(1, 1, 8388607, MODE_OVERRIDE, -32768, 0, 0);
		add_row(1, 32768, 256000, MODE_OVERRIDE, 32767, 0, 0);
		add_row(1, 65536, 9999, MODE_OVERRIDE, 0, 0, 0);
		add_row(1, 16384, 76800, MODE_OVERRIDE, 32767, 0, 0);
		add_row(1, 49152, 74240, MODE_WEIGHTED, 0, 0, 0);
		add_row(1, 16384, -256, MODE_WEIGHTED, 0, 0, 0);
		add_row(0, 65536, 0, MODE_WEIGHTED, 0, 0, 0);
		add_row(1, 65536, 71680, MODE_WEIGHTED, 0, -5, 1);
		add_row(1, 40000, 8388607, MODE_OVERRIDE, -1, 0, 1);
		add_row(1, 65536, -100, MODE_OVERRIDE, 7, 8388607, 1, 1, 0, 1, 1);
		add_row(1, 65536, 25600, MODE_WEIGHTED, 0, 0, 0);
		add_row(1, 65536, -25600, MODE_WEIGHTED, 0, 0, 1, 1, 0, 0, 0);
		add_row(1, 65535, 8388607, MODE_WEIGHTED, 0, 0, 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if ($urandom_range(0, 3) == 0) idle_items($urandom_range(1, 6));
			push_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
		end

		target = items_sent + RANDOM_ITEMS;
		qn = 0;
		while (items_sent < target) begin
			calm = (items_sent >= target - CALM_ITEMS);
			sender_gaps = $urandom_range(0, 1);
			if (qn == PAUSE_QUERY) begin
				idle_items(1);
				while (pending.size() != 0) @(posedge clk);
			end
			kind = $urandom_range(0, 99);
			if (qn == SAT_QUERY || qn == SAT_QUERY + 1) begin
				// Long runs at full scale drive the sums and influence totals into saturation.
				for (int k = 0; k < SAT_LEN; k++) begin
					c = random_contrib(k == SAT_LEN - 1);
					c.has = 1'b1;
					c.infl = 18'(65536);
					c.mode = (qn == SAT_QUERY) ? MODE_WEIGHTED : MODE_OVERRIDE;
					c.temp = (qn == SAT_QUERY) ? 24'h7FFFFF : 24'h800000;
					c.prio = 16'(3);
					offer(c);
				end
			end else if (kind < 15) begin
				len = $urandom_range(1, 5);
				for (int k = 0; k < len; k++) begin
					c = random_contrib($urandom_range(0, 2) == 0 || k == len - 1);
					if ($urandom_range(0, 1)) c.has = 1'b0;
					else c.infl = 18'(-int'($urandom_range(0, 131072)));
					offer(c);
				end
			end else begin
				len = (kind < 94) ? $urandom_range(1, 6) : $urandom_range(8, 24);
				for (int k = 0; k < len; k++) offer(random_contrib(k == len - 1));
			end
			qn++;
		end

		idle_items(1);
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending.size() == 0) begin
			$display("priority_override_weighted_blend_unit_tb OK");
		end else begin
			$display("priority_override_weighted_blend_unit_tb NOT OK");
		end
		$finish;
	end

	initial begin : result_sink
		int stall_left, hold_left, stall_pct, cycle;
		bit hold_done;
		stall_left = 0;
		hold_left = 0;
		stall_pct = 30;
		cycle = 0;
		hold_done = 1'b0;
		blend_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (blend_ch.valid && blend_ch.ready) take_result();
			cycle++;
			if (cycle % 256 == 0) stall_pct = $urandom_range(0, 1) ? 0 : 35;
			if (!hold_done && results_seen == LONG_HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				blend_ch.ready <= 1'b0;
			end else if (calm) begin
				blend_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				blend_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 6) - 1;
				blend_ch.ready <= 1'b0;
			end else begin
				blend_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#3_000_000;
		$display("priority_override_weighted_blend_unit_tb NOT OK");
		$finish;
	end

endmodule
